// ----- rtl/sparc_rela_relocation_apply_defines.svh -----
// Assertion macros for the SPARC RELA relocation block.
// Included by srela_patch, the only RTL file that carries concurrent checks; no other dependencies.
`ifndef SPARC_RELA_RELOCATION_APPLY_DEFINES_SVH
`define SPARC_RELA_RELOCATION_APPLY_DEFINES_SVH

`ifndef SYNTHESIS
`define SRELA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SRELA_ASSERT_NEVER(label, cond, msg) \
   `SRELA_ASSERT(label, !(cond), msg)
`else
`define SRELA_ASSERT(label, prop, msg)
`define SRELA_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ----- rtl/srela_pkg.sv -----
// Shared types, codes and the relocation type decode table.
// No dependencies; used by the decode, arith, patch and top-level files and the testbench.
`timescale 1ns / 1ps

package srela_pkg;

   // relocation type codes, densely renumbered
   localparam logic [4:0] CMD_NONE     = 5'd0;
   localparam logic [4:0] CMD_GLOB_DAT = 5'd1;
   localparam logic [4:0] CMD_RELATIVE = 5'd2;
   localparam logic [4:0] CMD_DISP32   = 5'd3;
   localparam logic [4:0] CMD_ABS32    = 5'd4;
   localparam logic [4:0] CMD_ABS8     = 5'd5;
   localparam logic [4:0] CMD_DISP8    = 5'd6;
   localparam logic [4:0] CMD_LO10     = 5'd7;
   localparam logic [4:0] CMD_PC10     = 5'd8;
   localparam logic [4:0] CMD_ABS13    = 5'd9;
   localparam logic [4:0] CMD_ABS16    = 5'd10;
   localparam logic [4:0] CMD_DISP16   = 5'd11;
   localparam logic [4:0] CMD_ABS22    = 5'd12;
   localparam logic [4:0] CMD_PC22     = 5'd13;
   localparam logic [4:0] CMD_WDISP22  = 5'd14;
   localparam logic [4:0] CMD_HI22     = 5'd15;
   localparam logic [4:0] CMD_WDISP30  = 5'd16;
   localparam logic [4:0] CMD_WPLT30   = 5'd17;
   localparam logic [4:0] CMD_UA32     = 5'd18;
   localparam logic [4:0] CMD_ABS10    = 5'd19;
   localparam logic [4:0] CMD_ABS11    = 5'd20;
   localparam logic [4:0] CMD_WDISP16  = 5'd21;
   localparam logic [4:0] CMD_WDISP19  = 5'd22;
   localparam logic [4:0] CMD_ABS5     = 5'd23;
   localparam logic [4:0] CMD_ABS6     = 5'd24;
   localparam logic [4:0] CMD_ABS7     = 5'd25;
   localparam logic [4:0] CMD_NUM_TYPES = 5'd26;

   // insertion kinds
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_WORD  = 3'd1;
   localparam logic [2:0] KIND_CHECK = 3'd2;
   localparam logic [2:0] KIND_TRUNC = 3'd3;
   localparam logic [2:0] KIND_UA32  = 3'd4;
   localparam logic [2:0] KIND_SPLIT = 3'd5;

   // result status
   localparam logic [2:0] ST_APPLIED = 3'd0;
   localparam logic [2:0] ST_SKIPPED = 3'd1;
   localparam logic [2:0] ST_RANGE   = 3'd2;
   localparam logic [2:0] ST_ALIGN   = 3'd3;
   localparam logic [2:0] ST_UNSUP   = 3'd4;

   // 16-bit split displacement layout
   localparam logic [31:0] SPLIT_HI_MASK  = 32'h0000_c000;
   localparam logic [31:0] SPLIT_LO_MASK  = 32'h0000_3fff;
   localparam int          SPLIT_HI_SHIFT = 6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  shift;
      logic        pcrel;
      logic [31:0] field_mask;  // low n bits set
      logic [31:0] sign_mask;   // bits n-1 and up set
   } dec_type;

   typedef struct packed {
      dec_type     dec;
      logic [31:0] op_a;
      logic        sub_pc;
      logic [31:0] target;
      logic [31:0] addend;
      logic [31:0] old_word;
      logic [2:0]  status;
   } s1_type;

   typedef struct packed {
      dec_type     dec;
      logic [31:0] value;
      logic [31:0] target;
      logic [31:0] addend;
      logic [31:0] old_word;
      logic [2:0]  status;
   } s2_type;

   typedef struct packed {
      dec_type     dec;
      logic [31:0] sum;
      logic [31:0] target;
      logic [31:0] old_word;
      logic [2:0]  status;
   } s3_type;

   function automatic dec_type decode_cmd(input logic [4:0] cmd);
      dec_type    d;
      logic [5:0] w;
      logic [32:0] one_w;
      d.kind  = KIND_NONE;
      d.shift = 4'd0;
      d.pcrel = 1'b0;
      w       = 6'd0;
      unique case (cmd)
         CMD_GLOB_DAT: begin d.kind = KIND_WORD; w = 6'd32; end
         CMD_RELATIVE: begin d.kind = KIND_WORD; w = 6'd32; end
         CMD_DISP32: begin d.kind = KIND_WORD; w = 6'd32; d.pcrel = 1'b1; end
         CMD_ABS32: begin d.kind = KIND_WORD; w = 6'd32; end
         CMD_ABS8: begin d.kind = KIND_CHECK; w = 6'd8; end
         CMD_DISP8: begin d.kind = KIND_CHECK; w = 6'd8; d.pcrel = 1'b1; end
         CMD_LO10: begin d.kind = KIND_TRUNC; w = 6'd10; end
         CMD_PC10: begin d.kind = KIND_TRUNC; w = 6'd10; d.pcrel = 1'b1; end
         CMD_ABS13: begin d.kind = KIND_CHECK; w = 6'd13; end
         CMD_ABS16: begin d.kind = KIND_CHECK; w = 6'd16; end
         CMD_DISP16: begin d.kind = KIND_CHECK; w = 6'd16; d.pcrel = 1'b1; end
         CMD_ABS22: begin d.kind = KIND_CHECK; w = 6'd22; end
         CMD_PC22: begin
            d.kind = KIND_CHECK; w = 6'd22; d.shift = 4'd10; d.pcrel = 1'b1;
         end
         CMD_WDISP22: begin
            d.kind = KIND_CHECK; w = 6'd22; d.shift = 4'd2; d.pcrel = 1'b1;
         end
         CMD_HI22: begin d.kind = KIND_TRUNC; w = 6'd22; d.shift = 4'd10; end
         CMD_WDISP30: begin
            d.kind = KIND_TRUNC; w = 6'd30; d.shift = 4'd2; d.pcrel = 1'b1;
         end
         CMD_WPLT30: begin
            d.kind = KIND_TRUNC; w = 6'd30; d.shift = 4'd2; d.pcrel = 1'b1;
         end
         CMD_UA32: begin d.kind = KIND_UA32; w = 6'd32; end
         CMD_ABS10: begin d.kind = KIND_CHECK; w = 6'd10; end
         CMD_ABS11: begin d.kind = KIND_CHECK; w = 6'd11; end
         CMD_WDISP16: begin
            d.kind = KIND_SPLIT; w = 6'd16; d.shift = 4'd2; d.pcrel = 1'b1;
         end
         CMD_WDISP19: begin
            d.kind = KIND_CHECK; w = 6'd19; d.shift = 4'd2; d.pcrel = 1'b1;
         end
         CMD_ABS5: begin d.kind = KIND_CHECK; w = 6'd5; end
         CMD_ABS6: begin d.kind = KIND_CHECK; w = 6'd6; end
         CMD_ABS7: begin d.kind = KIND_CHECK; w = 6'd7; end
         default: begin end
      endcase
      one_w        = 33'd1 << w;
      d.field_mask = 32'(one_w - 33'd1);
      d.sign_mask  = ~(d.field_mask >> 1);
      return d;
   endfunction

endpackage

// ----- rtl/srela_if.sv -----
// Handshake channel interfaces: relocation request, result and control write.
// Depends on nothing; used by the top level and the edge stages.
`timescale 1ns / 1ps

interface srela_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  cmd;
   logic [31:0] section_base;
   logic [31:0] rel_offset;
   logic signed [31:0] addend;
   logic [31:0] symbol_value;
   logic        symbol_is_local;
   logic        symbol_undefined;
   logic [31:0] old_word;

   modport source (output valid, cmd, section_base, rel_offset, addend, symbol_value,
                   symbol_is_local, symbol_undefined, old_word, input ready);
   modport sink (input valid, cmd, section_base, rel_offset, addend, symbol_value,
                 symbol_is_local, symbol_undefined, old_word, output ready);
endinterface

interface srela_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] target_address;
   logic [31:0] new_word;
   logic        flush_request;
   logic [2:0]  status;

   modport source (output valid, target_address, new_word, flush_request, status,
                   input ready);
   modport sink (input valid, target_address, new_word, flush_request, status,
                 output ready);
endinterface

interface srela_csr_if;
   logic valid;
   logic ready;
   logic flush_enable;

   modport source (output valid, flush_enable, input ready);
   modport sink (input valid, flush_enable, output ready);
endinterface

// ----- rtl/srela_decode.sv -----
// Stage 1: type decode, target address, case precedence and operand select.
// Depends on srela_pkg and srela_req_if.
`timescale 1ns / 1ps

module srela_decode (
   input  logic             clock,
   input  logic             reset,
   srela_req_if.sink        req,
   output srela_pkg::s1_type s1_data,
   output logic             s1_valid,
   input  logic             s1_ready
);

   logic             valid_ff, valid_in;
   srela_pkg::s1_type data_ff, data_in;
   logic             stage_ready, load;
   logic [31:0]      target;
   srela_pkg::dec_type dec;

   assign stage_ready = !valid_ff || s1_ready;
   assign load        = stage_ready && req.valid;
   assign valid_in    = stage_ready ? req.valid : valid_ff;
   assign req.ready   = stage_ready;

   assign target = req.section_base + req.rel_offset;
   assign dec    = srela_pkg::decode_cmd(req.cmd);

   always_comb begin
      data_in.dec      = dec;
      data_in.target   = target;
      data_in.addend   = req.addend;
      data_in.old_word = req.old_word;
      data_in.op_a     = (req.cmd == srela_pkg::CMD_RELATIVE) ? req.section_base
                                                             : req.symbol_value;
      data_in.sub_pc   = dec.pcrel && !req.symbol_is_local;
      if (req.cmd == srela_pkg::CMD_NONE) begin
         data_in.status = srela_pkg::ST_SKIPPED;
      end else if (req.cmd != srela_pkg::CMD_RELATIVE && req.symbol_undefined) begin
         data_in.status = srela_pkg::ST_SKIPPED;
      end else if (req.cmd != srela_pkg::CMD_UA32 && target[1:0] != 2'b00) begin
         data_in.status = srela_pkg::ST_ALIGN;
      end else if (req.cmd >= srela_pkg::CMD_NUM_TYPES) begin
         data_in.status = srela_pkg::ST_UNSUP;
      end else begin
         data_in.status = srela_pkg::ST_APPLIED;  // may still turn out of range
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign s1_data  = data_ff;
   assign s1_valid = valid_ff;

endmodule

// ----- rtl/srela_arith.sv -----
// Stages 2 and 3: PC subtraction, then addend sum.
// Depends on srela_pkg.
`timescale 1ns / 1ps

module srela_arith (
   input  logic              clock,
   input  logic              reset,
   input  srela_pkg::s1_type s1_data,
   input  logic              s1_valid,
   output logic              s1_ready,
   output srela_pkg::s3_type s3_data,
   output logic              s3_valid,
   input  logic              s3_ready
);

   logic              s2_valid_ff, s2_valid_in;
   logic              s3_valid_ff, s3_valid_in;
   srela_pkg::s2_type s2_ff, s2_in;
   srela_pkg::s3_type s3_ff, s3_in;
   logic              s2_stage_ready, s3_stage_ready;

   assign s3_stage_ready = !s3_valid_ff || s3_ready;
   assign s2_stage_ready = !s2_valid_ff || s3_stage_ready;
   assign s1_ready       = s2_stage_ready;

   assign s2_valid_in = s2_stage_ready ? s1_valid : s2_valid_ff;
   assign s3_valid_in = s3_stage_ready ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      s2_in.dec      = s1_data.dec;
      s2_in.target   = s1_data.target;
      s2_in.addend   = s1_data.addend;
      s2_in.old_word = s1_data.old_word;
      s2_in.status   = s1_data.status;
      s2_in.value    = s1_data.op_a - (s1_data.sub_pc ? s1_data.target : 32'd0);
   end

   always_comb begin
      s3_in.dec      = s2_ff.dec;
      s3_in.target   = s2_ff.target;
      s3_in.old_word = s2_ff.old_word;
      s3_in.status   = s2_ff.status;
      s3_in.sum      = s2_ff.value + s2_ff.addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_stage_ready && s1_valid) begin
         s2_ff <= s2_in;
      end
      if (s3_stage_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign s3_data  = s3_ff;
   assign s3_valid = s3_valid_ff;

endmodule

// ----- rtl/srela_patch.sv -----
// Stage 4: field extract, range check and word insertion into the result register.
// Depends on srela_pkg, srela_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "sparc_rela_relocation_apply_defines.svh"

module srela_patch (
   input  logic              clock,
   input  logic              reset,
   input  logic              flush_enable,
   input  srela_pkg::s3_type s3_data,
   input  logic              s3_valid,
   output logic              s3_ready,
   srela_rsp_if.source       rsp
);

   logic        valid_ff, valid_in;
   logic [31:0] target_ff, new_word_ff;
   logic        flush_ff;
   logic [2:0]  status_ff;
   logic        stage_ready, load;
   logic [31:0] x_logic, x_arith, x_field, x_top, patched, new_word;
   logic [2:0]  status;
   logic        fits;

   assign stage_ready = !valid_ff || rsp.ready;
   assign load        = stage_ready && s3_valid;
   assign valid_in    = stage_ready ? s3_valid : valid_ff;
   assign s3_ready    = stage_ready;

   assign x_logic = s3_data.sum >> s3_data.dec.shift;
   assign x_arith = 32'($signed(s3_data.sum) >>> s3_data.dec.shift);
   assign x_field = x_arith & s3_data.dec.field_mask;
   // in range when every bit from n-1 upward matches the sign
   assign x_top   = x_arith & s3_data.dec.sign_mask;
   assign fits    = (x_top == 32'd0) || (x_top == s3_data.dec.sign_mask);

   always_comb begin
      status  = s3_data.status;
      patched = s3_data.old_word;
      case (s3_data.dec.kind)
         srela_pkg::KIND_WORD: patched = s3_data.old_word + s3_data.sum;
         srela_pkg::KIND_UA32: patched = s3_data.sum;
         srela_pkg::KIND_TRUNC:
            patched = s3_data.old_word | (x_logic & s3_data.dec.field_mask);
         srela_pkg::KIND_CHECK: begin
            patched = s3_data.old_word | x_field;
            if (!fits && status == srela_pkg::ST_APPLIED) begin
               status = srela_pkg::ST_RANGE;
            end
         end
         srela_pkg::KIND_SPLIT: begin
            patched = s3_data.old_word
                    | ((x_field & srela_pkg::SPLIT_HI_MASK) << srela_pkg::SPLIT_HI_SHIFT)
                    | (x_field & srela_pkg::SPLIT_LO_MASK);
            if (!fits && status == srela_pkg::ST_APPLIED) begin
               status = srela_pkg::ST_RANGE;
            end
         end
         default: begin
            if (status == srela_pkg::ST_APPLIED) begin
               status = srela_pkg::ST_UNSUP;
            end
         end
      endcase
      new_word = (status == srela_pkg::ST_APPLIED) ? patched : s3_data.old_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         target_ff   <= s3_data.target;
         new_word_ff <= new_word;
         flush_ff    <= flush_enable && (status == srela_pkg::ST_APPLIED);
         status_ff   <= status;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.target_address = target_ff;
   assign rsp.new_word       = new_word_ff;
   assign rsp.flush_request  = flush_ff;
   assign rsp.status         = status_ff;

   `SRELA_ASSERT_NEVER(a_flush_only_applied, valid_ff && flush_ff && status_ff != srela_pkg::ST_APPLIED, "flush raised for an item that was not applied")
   `SRELA_ASSERT(a_range_from_checked, (load && status == srela_pkg::ST_RANGE) |-> (s3_data.dec.kind == srela_pkg::KIND_CHECK || s3_data.dec.kind == srela_pkg::KIND_SPLIT), "range status from an unchecked kind")
   `SRELA_ASSERT(a_load_shows, load |=> (valid_ff && status_ff == $past(status) && new_word_ff == $past(new_word)), "loaded item not presented")

endmodule

// ----- rtl/sparc_rela_relocation_apply.sv -----
// Top level of the ELF32 SPARC RELA relocation block: control register and stages.
// Depends on srela_pkg, the channel interfaces, srela_decode, srela_arith, srela_patch.
`timescale 1ns / 1ps
//
//  channel | dir | contents
//  --------+-----+-----------------------------------------------------------
//  req_ch  | in  | one relocation record plus the old target word
//  rsp_ch  | out | target address, new word, flush request, status
//  csr_ch  | in  | write of flush_enable (always ready)
//
//  Four register stages: decode and target add, PC subtract, addend add,
//  insert and check into the result register. One item per cycle while rsp_ch
//  is not stalled.
//  Synchronous active-high reset clears all valid bits and flush_enable.
//  A stall at rsp_ch backs up stage by stage; each stage takes a new item
//  whenever it is empty or its successor moves, so nothing is lost or repeated.

module sparc_rela_relocation_apply (
   input  logic       clock,
   input  logic       reset,
   srela_req_if.sink  req_ch,
   srela_rsp_if.source rsp_ch,
   srela_csr_if.sink  csr_ch
);

   logic              flush_enable_ff, flush_enable_in;
   srela_pkg::s1_type s1_data;
   logic              s1_valid, s1_ready;
   srela_pkg::s3_type s3_data;
   logic              s3_valid, s3_ready;

   assign csr_ch.ready    = 1'b1;
   assign flush_enable_in = csr_ch.valid ? csr_ch.flush_enable : flush_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_enable_ff <= 1'b0;
      end else begin
         flush_enable_ff <= flush_enable_in;
      end
   end

   srela_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .s1_data  (s1_data),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready)
   );

   srela_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .s1_data  (s1_data),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s3_data  (s3_data),
      .s3_valid (s3_valid),
      .s3_ready (s3_ready)
   );

   srela_patch u_patch (
      .clock        (clock),
      .reset        (reset),
      .flush_enable (flush_enable_ff),
      .s3_data      (s3_data),
      .s3_valid     (s3_valid),
      .s3_ready     (s3_ready),
      .rsp          (rsp_ch)
   );

endmodule

// ----- tb/sparc_rela_relocation_apply_test.sv -----
`timescale 1ns / 1ps
// Testbench for sparc_rela_relocation_apply: directed and random relocation records,
// each result checked against a scoreboard prediction. Depends on srela_pkg and srela_if.

module sparc_rela_relocation_apply_test;

   localparam int IDLE_LIMIT       = 4000;
   localparam int RANDOM_PER_PHASE = 440;

   typedef struct packed {
      logic [4:0]  cmd;
      logic [31:0] section_base;
      logic [31:0] rel_offset;
      logic [31:0] addend;
      logic [31:0] symbol_value;
      logic        symbol_is_local;
      logic        symbol_undefined;
      logic [31:0] old_word;
   } reloc_req_type;

   typedef struct packed {
      logic [31:0] target_address;
      logic [31:0] new_word;
      logic        flush_request;
      logic [2:0]  status;
   } reloc_rsp_type;

   class reloc_scoreboard;
      reloc_rsp_type expected_patches[$];
      logic          flush_en;
      int            mismatches;
      int            results_seen;

      function new();
         flush_en     = 1'b0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      task report(string msg);
         $display("error: %s (result %0d)", msg, results_seen);
         mismatches++;
      endtask

      function logic [31:0] low_ones(int n);
         return (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
      endfunction

      // insertion rule of each relocation type
      function void shape(input logic [4:0] c, output logic [2:0] kind, output int width,
                          output int shift, output bit pcrel);
         kind  = srela_pkg::KIND_NONE;
         width = 0;
         shift = 0;
         pcrel = 1'b0;
         case (c) inside
            srela_pkg::CMD_GLOB_DAT, srela_pkg::CMD_RELATIVE, srela_pkg::CMD_ABS32: begin
               kind = srela_pkg::KIND_WORD; width = 32;
            end
            srela_pkg::CMD_DISP32: begin
               kind = srela_pkg::KIND_WORD; width = 32; pcrel = 1'b1;
            end
            srela_pkg::CMD_ABS8: begin kind = srela_pkg::KIND_CHECK; width = 8; end
            srela_pkg::CMD_DISP8: begin
               kind = srela_pkg::KIND_CHECK; width = 8; pcrel = 1'b1;
            end
            srela_pkg::CMD_LO10: begin kind = srela_pkg::KIND_TRUNC; width = 10; end
            srela_pkg::CMD_PC10: begin
               kind = srela_pkg::KIND_TRUNC; width = 10; pcrel = 1'b1;
            end
            srela_pkg::CMD_ABS13: begin kind = srela_pkg::KIND_CHECK; width = 13; end
            srela_pkg::CMD_ABS16: begin kind = srela_pkg::KIND_CHECK; width = 16; end
            srela_pkg::CMD_DISP16: begin
               kind = srela_pkg::KIND_CHECK; width = 16; pcrel = 1'b1;
            end
            srela_pkg::CMD_ABS22: begin kind = srela_pkg::KIND_CHECK; width = 22; end
            srela_pkg::CMD_PC22: begin
               kind = srela_pkg::KIND_CHECK; width = 22; shift = 10; pcrel = 1'b1;
            end
            srela_pkg::CMD_WDISP22: begin
               kind = srela_pkg::KIND_CHECK; width = 22; shift = 2; pcrel = 1'b1;
            end
            srela_pkg::CMD_HI22: begin
               kind = srela_pkg::KIND_TRUNC; width = 22; shift = 10;
            end
            srela_pkg::CMD_WDISP30, srela_pkg::CMD_WPLT30: begin
               kind = srela_pkg::KIND_TRUNC; width = 30; shift = 2; pcrel = 1'b1;
            end
            srela_pkg::CMD_UA32: begin kind = srela_pkg::KIND_UA32; width = 32; end
            srela_pkg::CMD_ABS10: begin kind = srela_pkg::KIND_CHECK; width = 10; end
            srela_pkg::CMD_ABS11: begin kind = srela_pkg::KIND_CHECK; width = 11; end
            srela_pkg::CMD_WDISP16: begin
               kind = srela_pkg::KIND_SPLIT; width = 16; shift = 2; pcrel = 1'b1;
            end
            srela_pkg::CMD_WDISP19: begin
               kind = srela_pkg::KIND_CHECK; width = 19; shift = 2; pcrel = 1'b1;
            end
            srela_pkg::CMD_ABS5: begin kind = srela_pkg::KIND_CHECK; width = 5; end
            srela_pkg::CMD_ABS6: begin kind = srela_pkg::KIND_CHECK; width = 6; end
            srela_pkg::CMD_ABS7: begin kind = srela_pkg::KIND_CHECK; width = 7; end
            default: begin end
         endcase
      endfunction

      function reloc_rsp_type predict_patch(reloc_req_type r);
         reloc_rsp_type      p;
         logic [2:0]         kind;
         int                 width, shift;
         bit                 pcrel;
         logic [31:0]        value, sum, xm;
         logic signed [31:0] xs, top;
         shape(r.cmd, kind, width, shift, pcrel);
         p.target_address = r.section_base + r.rel_offset;
         p.new_word       = r.old_word;
         p.status         = srela_pkg::ST_APPLIED;
         if (r.cmd == srela_pkg::CMD_NONE) begin
            p.status = srela_pkg::ST_SKIPPED;
         end else if (r.cmd != srela_pkg::CMD_RELATIVE && r.symbol_undefined) begin
            p.status = srela_pkg::ST_SKIPPED;
         end else if (r.cmd != srela_pkg::CMD_UA32 && p.target_address[1:0] != 2'b00) begin
            p.status = srela_pkg::ST_ALIGN;
         end else if (r.cmd >= srela_pkg::CMD_NUM_TYPES) begin
            p.status = srela_pkg::ST_UNSUP;
         end else begin
            if (r.cmd == srela_pkg::CMD_RELATIVE) begin
               value = r.section_base;
            end else begin
               value = r.symbol_value;
               if (!r.symbol_is_local && pcrel) value = value - p.target_address;
            end
            sum = value + r.addend;
            case (kind) inside
               srela_pkg::KIND_WORD: p.new_word = r.old_word + sum;
               srela_pkg::KIND_UA32: p.new_word = sum;
               srela_pkg::KIND_TRUNC:
                  p.new_word = r.old_word | ((sum >> shift) & low_ones(width));
               srela_pkg::KIND_CHECK, srela_pkg::KIND_SPLIT: begin
                  xs  = $signed(sum) >>> shift;
                  top = xs >>> (width - 1);
                  if (top == 32'sd0 || (&top)) begin
                     xm = xs & low_ones(width);
                     if (kind == srela_pkg::KIND_SPLIT)
                        p.new_word = r.old_word
                                     | ((xm & srela_pkg::SPLIT_HI_MASK)
                                        << srela_pkg::SPLIT_HI_SHIFT)
                                     | (xm & srela_pkg::SPLIT_LO_MASK);
                     else
                        p.new_word = r.old_word | xm;
                  end else begin
                     p.status = srela_pkg::ST_RANGE;
                  end
               end
               default: p.status = srela_pkg::ST_UNSUP;
            endcase
         end
         if (p.status != srela_pkg::ST_APPLIED) p.new_word = r.old_word;
         p.flush_request = (p.status == srela_pkg::ST_APPLIED) ? flush_en : 1'b0;
         return p;
      endfunction

      function void note_request(reloc_req_type r);
         expected_patches.push_back(predict_patch(r));
      endfunction

      task check_result(reloc_rsp_type got);
         reloc_rsp_type want;
         results_seen++;
         if (expected_patches.size() == 0) begin
            report($sformatf("result with nothing pending, address %h", got.target_address));
            return;
         end
         want = expected_patches.pop_front();
         if (got.target_address !== want.target_address)
            report($sformatf("target_address %h, want %h", got.target_address,
                             want.target_address));
         if (got.new_word !== want.new_word)
            report($sformatf("new_word %h, want %h at %h", got.new_word, want.new_word,
                             want.target_address));
         if (got.flush_request !== want.flush_request)
            report($sformatf("flush_request %b, want %b at %h", got.flush_request,
                             want.flush_request, want.target_address));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d at %h", got.status, want.status,
                             want.target_address));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   int   idle_cycles   = 0;
   int   items_sent    = 0;
   reloc_scoreboard sb;

   srela_req_if req_ch();
   srela_rsp_if rsp_ch();
   srela_csr_if csr_ch();

   sparc_rela_relocation_apply u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // all handshakes sampled here, before any of this edge's updates land
   always @(posedge clock) begin : monitor
      reloc_req_type seen;
      reloc_rsp_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen = '{req_ch.cmd, req_ch.section_base, req_ch.rel_offset, req_ch.addend,
                     req_ch.symbol_value, req_ch.symbol_is_local, req_ch.symbol_undefined,
                     req_ch.old_word};
            sb.note_request(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.target_address, rsp_ch.new_word, rsp_ch.flush_request,
                    rsp_ch.status};
            sb.check_result(got);
         end
         if (csr_ch.valid && csr_ch.ready) sb.flush_en = csr_ch.flush_enable;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_reloc(input reloc_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.cmd              <= r.cmd;
      req_ch.section_base     <= r.section_base;
      req_ch.rel_offset       <= r.rel_offset;
      req_ch.addend           <= r.addend;
      req_ch.symbol_value     <= r.symbol_value;
      req_ch.symbol_is_local  <= r.symbol_is_local;
      req_ch.symbol_undefined <= r.symbol_undefined;
      req_ch.old_word         <= r.old_word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_patches.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_flush(input logic fe);
      drain_results();
      csr_ch.valid        <= 1'b1;
      csr_ch.flush_enable <= fe;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // one record per type code and the first unsupported code, some bent toward a corner case, then a few extremes
   task automatic run_directed();
      reloc_req_type r;
      for (int c = srela_pkg::CMD_NONE; c <= srela_pkg::CMD_NUM_TYPES; c++) begin
         r.cmd              = 5'(c);
         r.section_base     = 32'h4000_0000;
         r.rel_offset       = 32'(c * 4);
         r.addend           = 32'd4;
         r.symbol_value     = 32'h10;
         r.symbol_is_local  = c[0];
         r.symbol_undefined = 1'b0;
         r.old_word         = 32'hA5A0_0000;
         case (5'(c))
            srela_pkg::CMD_GLOB_DAT: r.symbol_undefined = 1'b1;
            srela_pkg::CMD_RELATIVE: begin
               r.symbol_undefined = 1'b1;  // relative ignores the symbol
               r.section_base     = 32'hFFFF_FFF0;
               r.rel_offset       = 32'h0000_0018;
            end
            srela_pkg::CMD_ABS32: begin
               r.addend = 32'h8000_0000; r.old_word = 32'hFFFF_FFFF;
            end
            srela_pkg::CMD_ABS8: begin r.symbol_value = 32'h7F; r.addend = 32'd1; end
            srela_pkg::CMD_DISP8: begin
               r.symbol_is_local = 1'b0;
               r.symbol_value    = r.section_base + r.rel_offset - 32'd132;
            end
            srela_pkg::CMD_HI22: r.symbol_value = 32'hFFFF_FFFF;
            srela_pkg::CMD_UA32: r.rel_offset = r.rel_offset + 32'd1;
            srela_pkg::CMD_ABS7: r.addend = 32'h7FFF_FFFF;
            srela_pkg::CMD_NUM_TYPES: r.rel_offset = r.rel_offset + 32'd2;
            default: begin end
         endcase
         push_reloc(r);
      end
      push_reloc('{srela_pkg::CMD_NUM_TYPES, 32'h1000, 32'h20, 32'd0, 32'd0, 1'b1, 1'b0,
                   32'h1});
      push_reloc('{srela_pkg::CMD_ABS5, 32'h1000, 32'h3, 32'd1, 32'd2, 1'b1, 1'b1, 32'h2});
      push_reloc('{srela_pkg::CMD_ABS32, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0});
      push_reloc('{srela_pkg::CMD_ABS16, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   1'b1, 1'b0, 32'hFFFF_FFFF});
      // most negative split displacement that still fits
      push_reloc('{srela_pkg::CMD_WDISP16, 32'h0010_0000, 32'h40, 32'd8, 32'h000E_0038,
                   1'b0, 1'b0, 32'h0});
   endtask

   function automatic reloc_req_type gen_reloc();
      reloc_req_type r;
      logic [2:0]    kind;
      int            width, shift, span, m, pick;
      bit            pcrel;
      logic [31:0]   target, want, half, pc;
      pick = $urandom_range(99);
      if (pick < 3)
         r.cmd = srela_pkg::CMD_NONE;
      else if (pick < 6)
         r.cmd = srela_pkg::CMD_NUM_TYPES;
      else
         r.cmd = 5'($urandom_range(srela_pkg::CMD_ABS7, srela_pkg::CMD_GLOB_DAT));
      r.section_base = $urandom;
      r.rel_offset   = $urandom;
      if ($urandom_range(99) < 88) begin
         target       = r.section_base + r.rel_offset;
         r.rel_offset = r.rel_offset - {30'd0, target[1:0]};
      end
      r.symbol_is_local  = 1'($urandom_range(1));
      r.symbol_undefined = ($urandom_range(99) < 8);
      r.old_word         = $urandom_range(1) ? $urandom : ($urandom & 32'hFFC0_0000);
      r.addend           = $urandom;
      r.symbol_value     = $urandom;
      sb.shape(r.cmd, kind, width, shift, pcrel);
      // steer S + A (- P) around the edges of the field's range
      if (kind != srela_pkg::KIND_NONE && r.cmd != srela_pkg::CMD_RELATIVE
          && $urandom_range(99) < 65) begin
         span = (width + shift > 32) ? 32 : width + shift;
         half = 32'h1 << (span - 1);
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: want = half - 32'd1;
               1: want = half;
               2: want = -half;
               default: want = -half - 32'd1;
            endcase
         end else begin
            m    = $urandom_range(span);
            want = (m == 0) ? 32'd0 : ($urandom & sb.low_ones(m));
            if ($urandom_range(1)) want = -want;
         end
         if ($urandom_range(1)) r.addend = $urandom_range(255) - 128;
         target         = r.section_base + r.rel_offset;
         pc             = (!r.symbol_is_local && pcrel) ? target : 32'd0;
         r.symbol_value = want - r.addend + pc;
      end
      return r;
   endfunction

   task automatic run_phase(input int n, input int idle, input int stall, input logic fe);
      write_flush(fe);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) push_reloc(gen_reloc());
   endtask

   initial begin
      sb = new();
      req_ch.valid            <= 1'b0;
      req_ch.cmd              <= srela_pkg::CMD_NONE;
      req_ch.section_base     <= 32'd0;
      req_ch.rel_offset       <= 32'd0;
      req_ch.addend           <= 32'd0;
      req_ch.symbol_value     <= 32'd0;
      req_ch.symbol_is_local  <= 1'b0;
      req_ch.symbol_undefined <= 1'b0;
      req_ch.old_word         <= 32'd0;
      csr_ch.valid            <= 1'b0;
      csr_ch.flush_enable     <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_flush(1'b1);
      run_directed();
      run_phase(RANDOM_PER_PHASE, 0, 0, 1'b0);
      run_phase(RANDOM_PER_PHASE, 84, 0, 1'b1);
      run_phase(RANDOM_PER_PHASE, 0, 84, 1'b0);
      run_phase(RANDOM_PER_PHASE, 30, 30, 1'b1);
      drain_results();
      repeat (10) @(posedge clock);
      if (sb.expected_patches.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_patches.size()));

      $display("%0d relocation records sent, %0d results checked, %0d errors",
               items_sent, sb.results_seen, sb.mismatches);
      $display("covered all types, both flush settings, sender gaps and receiver stalls");
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/srela_pkg.sv
rtl/srela_if.sv
rtl/srela_decode.sv
rtl/srela_arith.sv
rtl/srela_patch.sv
rtl/sparc_rela_relocation_apply.sv
tb/sparc_rela_relocation_apply_test.sv
